### rtl/core/fpvp_pkg.sv
package fpvp_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam logic [31:0] DIVIDEND = 32'h7fffffff;
    localparam logic [31:0] DEPTH_REJECT = 32'h7fffffff;
    localparam logic [31:0] HALF = 32'd32768;
    localparam logic [31:0] ONE = 32'd65536;
    localparam int QBITS = 31;
    localparam int NUM_REGS = 8;
    localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

    // one beat travelling down the divider chain
    typedef struct packed {
        logic        valid;
        logic        rejected;
        logic [31:0] clip_x;
        logic [31:0] clip_y;
        logic [31:0] clip_z;
        logic        w_neg;
        logic [31:0] w_mag;
        logic        z_neg;
        logic [31:0] z_mag;
        logic [31:0] w_rem;
        logic [30:0] w_quo;
        logic [31:0] z_rem;
        logic [30:0] z_quo;
    } div_beat_t;

endpackage

### rtl/core/fpvp_div_cell.sv
// one restoring-division step for both reciprocals
module fpvp_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [4:0]            bit_idx,
    input  fpvp_pkg::div_beat_t   din,
    output fpvp_pkg::div_beat_t   dout
);
    fpvp_pkg::div_beat_t beat_next;
    fpvp_pkg::div_beat_t beat_reg;
    logic                valid_reg;
    logic [32:0] w_trial;
    logic [32:0] z_trial;

    always_comb
    begin
        beat_next = din;
        w_trial = {din.w_rem, fpvp_pkg::DIVIDEND[bit_idx]};
        z_trial = {din.z_rem, fpvp_pkg::DIVIDEND[bit_idx]};
        if (w_trial >= {1'b0, din.w_mag})
        begin
            beat_next.w_rem = 32'(w_trial - {1'b0, din.w_mag});
            beat_next.w_quo[bit_idx] = 1'b1;
        end
        else
        begin
            beat_next.w_rem = w_trial[31:0];
        end
        if (z_trial >= {1'b0, din.z_mag})
        begin
            beat_next.z_rem = 32'(z_trial - {1'b0, din.z_mag});
            beat_next.z_quo[bit_idx] = 1'b1;
        end
        else
        begin
            beat_next.z_rem = z_trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_comb
    begin
        dout = beat_reg;
        dout.valid = valid_reg;
    end
endmodule

### rtl/core/fpvp_transform.sv
// matrix times [x y z 1]: products, then sums, two register stages
module fpvp_transform (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [31:0]  vx,
    input  logic [31:0]  vy,
    input  logic [31:0]  vz,
    input  logic [63:0]  mat [fpvp_pkg::NUM_REGS],
    output logic         out_valid,
    output logic [31:0]  clip [4]
);
    logic signed [63:0] prod_reg [4][4];
    logic signed [63:0] prod_next [4][4];
    logic               v1_reg;
    logic               v2_reg;
    logic [31:0]        clip_reg [4];
    logic [31:0]        clip_next [4];
    logic signed [31:0] vec [4];
    logic signed [31:0] coef;
    logic [63:0]        word;
    logic [63:0]        acc;

    always_comb
    begin
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        vec[3] = fpvp_pkg::ONE;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                word = mat[3'(r * 2 + c / 2)];
                coef = (c % 2 == 1) ? word[63:32] : word[31:0];
                prod_next[r][c] = 64'(coef) * 64'(vec[c]);
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            acc = prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2] + prod_reg[r][3];
            clip_next[r] = acc[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        clip_reg <= clip_next;
    end

    assign out_valid = v2_reg;
    assign clip = clip_reg;
endmodule

### rtl/core/fpvp_viewport.sv
// sign fix of the quotients, x/y scaling by 1/w, pixel mapping
module fpvp_viewport (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpvp_pkg::div_beat_t  din,
    output logic                 out_valid,
    output logic                 out_rejected,
    output logic [15:0]          out_sx,
    output logic [15:0]          out_sy,
    output logic [31:0]          out_depth,
    output logic [31:0]          out_drecip
);
    logic [31:0]        winv;
    logic [31:0]        zinv;
    logic [31:0]        wq;
    logic [31:0]        zq;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               rej1_reg, rej2_reg, rej3_reg;
    logic [31:0]        z1_reg, z2_reg, z3_reg;
    logic [31:0]        zr1_reg, zr2_reg, zr3_reg;
    logic signed [63:0] px_reg, py_reg;
    logic [31:0]        tx_reg, ty_reg;
    logic [31:0]        tx_next, ty_next;
    logic [31:0]        mx_reg, my_reg;
    logic [31:0]        px32, py32;

    always_comb
    begin
        wq = {1'b0, din.w_quo};
        zq = {1'b0, din.z_quo};
        winv = (din.w_neg ? 32'(-wq) : wq) << 1;
        zinv = (din.z_neg ? 32'(-zq) : zq) << 1;
        px32 = px_reg[47:16];
        py32 = py_reg[47:16];
        tx_next = fpvp_pkg::HALF + 32'($signed(px32) >>> 1);
        ty_next = fpvp_pkg::HALF + 32'($signed(py32) >>> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= 64'($signed(din.clip_x)) * 64'($signed(winv));
        py_reg  <= 64'($signed(din.clip_y)) * 64'($signed(winv));
        rej1_reg <= din.rejected;
        z1_reg  <= din.clip_z;
        zr1_reg <= zinv;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        rej2_reg <= rej1_reg;
        z2_reg  <= z1_reg;
        zr2_reg <= zr1_reg;
        mx_reg  <= 32'(tx_reg * 32'(fpvp_pkg::SCREEN_WIDTH));
        my_reg  <= 32'(ty_reg * 32'(fpvp_pkg::SCREEN_HEIGHT));
        rej3_reg <= rej2_reg;
        z3_reg  <= z2_reg;
        zr3_reg <= zr2_reg;
    end

    assign out_valid    = v3_reg;
    assign out_rejected = rej3_reg;
    assign out_sx       = rej3_reg ? 16'd0 : mx_reg[31:16];
    assign out_sy       = rej3_reg ? 16'd0 : my_reg[31:16];
    assign out_depth    = rej3_reg ? fpvp_pkg::DEPTH_REJECT : z3_reg;
    assign out_drecip   = rej3_reg ? 32'd0 : zr3_reg;
endmodule

### rtl/core/fixed_point_vertex_projection_unit.sv
// Fixed-point vertex projection unit.
// Pulse start with vertex_x/y/z (signed 16.16) whenever busy is low; busy is
// never raised, so one vertex may enter every cycle.
// Each vertex gives exactly one result beat: done is high for one cycle with
// rejected, screen_x, screen_y, depth and depth_reciprocal valid alongside.
// From start to done a vertex passes the registered matrix products and row
// sums, 31 cells of the divider chain (one quotient bit per cell, both
// reciprocals side by side) and the registered viewport mapping.
// Throughput is one vertex per cycle, set by the chain of divider cells.
// The matrix is written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, indexes above seven are ignored. Write only when idle.
// Reset loads the identity matrix and empties the pipeline.
// The receiver cannot stall; results are presented once and not held.
module fixed_point_vertex_projection_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [31:0]  vertex_x,
    input  logic [31:0]  vertex_y,
    input  logic [31:0]  vertex_z,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output logic         done,
    output logic         rejected,
    output logic [15:0]  screen_x,
    output logic [15:0]  screen_y,
    output logic [31:0]  depth,
    output logic [31:0]  depth_reciprocal
);
    logic [63:0]         mat_reg [fpvp_pkg::NUM_REGS];
    logic                t_valid;
    logic [31:0]         clip [4];
    fpvp_pkg::div_beat_t chain_head;
    fpvp_pkg::div_beat_t chain [fpvp_pkg::QBITS + 1];
    logic                accept;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[fpvp_pkg::REG_ROW0_COLS01] <= 64'd65536;
            mat_reg[fpvp_pkg::REG_ROW0_COLS23] <= 64'd0;
            mat_reg[fpvp_pkg::REG_ROW1_COLS01] <= 64'd65536 << 32;
            mat_reg[fpvp_pkg::REG_ROW1_COLS23] <= 64'd0;
            mat_reg[fpvp_pkg::REG_ROW2_COLS01] <= 64'd0;
            mat_reg[fpvp_pkg::REG_ROW2_COLS23] <= 64'd65536;
            mat_reg[fpvp_pkg::REG_ROW3_COLS01] <= 64'd0;
            mat_reg[fpvp_pkg::REG_ROW3_COLS23] <= 64'd65536 << 32;
        end
        else if (cfg_valid && cfg_ready && !cfg_index[3])
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    fpvp_transform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vx        (vertex_x),
        .vy        (vertex_y),
        .vz        (vertex_z),
        .mat       (mat_reg),
        .out_valid (t_valid),
        .clip      (clip)
    );

    // chain entry: magnitudes of w and z; a divisor of -2^31 gives quotient 0
    always_comb
    begin
        chain_head = '0;
        chain_head.valid    = t_valid;
        chain_head.rejected = (clip[2] == 32'd0) || (clip[3] == 32'd0);
        chain_head.clip_x   = clip[0];
        chain_head.clip_y   = clip[1];
        chain_head.clip_z   = clip[2];
        chain_head.w_neg    = clip[3][31];
        chain_head.w_mag    = clip[3][31] ? 32'(-clip[3]) : clip[3];
        chain_head.z_neg    = clip[2][31];
        chain_head.z_mag    = clip[2][31] ? 32'(-clip[2]) : clip[2];
    end

    assign chain[0] = chain_head;

    for (genvar i = 0; i < fpvp_pkg::QBITS; i++)
    begin : g_div
        fpvp_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bit_idx (5'(fpvp_pkg::QBITS - 1 - i)),
            .din     (chain[i]),
            .dout    (chain[i + 1])
        );
    end

    fpvp_viewport u_view (
        .clk          (clk),
        .rst_n        (rst_n),
        .din          (chain[fpvp_pkg::QBITS]),
        .out_valid    (done),
        .out_rejected (rejected),
        .out_sx       (screen_x),
        .out_sy       (screen_y),
        .out_depth    (depth),
        .out_drecip   (depth_reciprocal)
    );

    a_reject_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected |-> depth == fpvp_pkg::DEPTH_REJECT && depth_reciprocal == 32'd0)
        else $error("rejected beat with bad depth");
    a_accept_lat: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid |-> $past(accept, 2))
        else $error("transform valid without accepted vertex");
    a_chain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        chain[fpvp_pkg::QBITS].valid |-> $past(t_valid, fpvp_pkg::QBITS))
        else $error("divider chain valid out of step");
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [3:0] REG_UNUSED_LO = 4'd8;
    localparam int PIPE_DEPTH = 38;

    typedef enum logic [1:0] { OP_VERTEX, OP_CFG, OP_DRAIN } op_t;

    typedef struct {
        op_t         op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [3:0]  idx;
        logic [63:0] data;
        logic        burst;
    } stim_t;

    typedef struct packed {
        logic        rejected;
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic [31:0] depth;
        logic [31:0] depth_reciprocal;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] vertex_x = '0;
    logic [31:0] vertex_y = '0;
    logic [31:0] vertex_z = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic        rejected;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic [31:0] depth;
    logic [31:0] depth_reciprocal;

    stim_t       pending[$];
    pixel_t      expected_pixels[$];
    logic [63:0] matrix[fpvp_pkg::NUM_REGS];
    int          fails = 0;
    int          gap = 0;
    int          quiet = 0;

    always #1 clk = ~clk;

    fixed_point_vertex_projection_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .rejected(rejected),
        .screen_x(screen_x), .screen_y(screen_y), .depth(depth),
        .depth_reciprocal(depth_reciprocal)
    );

    function automatic logic [31:0] reciprocal(logic signed [31:0] d);
        longint q;
        logic [63:0] t;
        q = longint'(32'sh7fffffff) / longint'(d);
        t = q << 1;
        return t[31:0];
    endfunction

    function automatic logic [15:0] to_screen(logic signed [31:0] c,
                                              logic signed [31:0] winv, int size);
        longint p;
        longint t;
        longint m;
        logic signed [31:0] px;
        p = longint'(c) * longint'(winv);
        px = p[47:16];
        t = 32768 + longint'(px >>> 1);
        m = t * size;
        return m[31:16];
    endfunction

    function automatic pixel_t project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [31:0] vec[4];
        logic signed [31:0] clip[4];
        logic signed [31:0] coef;
        logic [63:0] acc;
        logic [63:0] word;
        longint prod;
        pixel_t res;
        vec[0] = x;
        vec[1] = y;
        vec[2] = z;
        vec[3] = fpvp_pkg::ONE;
        for (int r = 0; r < 4; r++)
        begin
            acc = '0;
            for (int c = 0; c < 4; c++)
            begin
                word = matrix[r * 2 + c / 2];
                coef = (c % 2) ? word[63:32] : word[31:0];
                prod = longint'(coef) * longint'(vec[c]);
                acc = acc + prod;
            end
            clip[r] = acc[47:16];
        end
        res = '0;
        if (clip[2] == 0 || clip[3] == 0)
        begin
            res.rejected = 1'b1;
            res.depth = fpvp_pkg::DEPTH_REJECT;
        end
        else
        begin
            res.screen_x = to_screen(clip[0], reciprocal(clip[3]), fpvp_pkg::SCREEN_WIDTH);
            res.screen_y = to_screen(clip[1], reciprocal(clip[3]), fpvp_pkg::SCREEN_HEIGHT);
            res.depth = clip[2];
            res.depth_reciprocal = reciprocal(clip[2]);
        end
        return res;
    endfunction

    // driver: one beat per accepted start or config write
    always @(posedge clk or negedge rst_n)
    begin
        logic next_start;
        logic next_cfg;
        stim_t it;
        int r;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            matrix[0] = 64'd65536;
            matrix[1] = 64'd0;
            matrix[2] = 64'd65536 << 32;
            matrix[3] = 64'd0;
            matrix[4] = 64'd0;
            matrix[5] = 64'd65536;
            matrix[6] = 64'd0;
            matrix[7] = 64'd65536 << 32;
        end
        else
        begin
            next_start = 1'b0;
            next_cfg = 1'b0;
            if (start && !busy)
                expected_pixels.push_back(project(vertex_x, vertex_y, vertex_z));
            if (cfg_valid && cfg_ready && cfg_index < REG_UNUSED_LO)
                matrix[cfg_index[2:0]] = cfg_data;
            if (expected_pixels.size() == 0 && !start)
                quiet = quiet + 1;
            else
                quiet = 0;

            if (start && busy)
                next_start = 1'b1;
            else if (cfg_valid && !cfg_ready)
                next_cfg = 1'b1;
            else if (gap > 0)
                gap = gap - 1;
            else if (pending.size() > 0)
            begin
                it = pending[0];
                if (it.op == OP_VERTEX)
                begin
                    void'(pending.pop_front());
                    vertex_x <= it.x;
                    vertex_y <= it.y;
                    vertex_z <= it.z;
                    next_start = 1'b1;
                    r = $urandom_range(0, 99);
                    if (it.burst || r < 60)
                        gap = 0;
                    else if (r < 92)
                        gap = $urandom_range(1, 3);
                    else
                        gap = $urandom_range(4, 40);
                end
                else if (quiet > PIPE_DEPTH + 2 && !cfg_valid)
                begin
                    void'(pending.pop_front());
                    if (it.op == OP_CFG)
                    begin
                        cfg_index <= it.idx;
                        cfg_data <= it.data;
                        next_cfg = 1'b1;
                    end
                end
            end
            start <= next_start;
            cfg_valid <= next_cfg;
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result beat with none expected", $time);
                fails++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (rejected !== want.rejected)
                begin
                    $display("%0t: rejected exp %0h got %0h", $time, want.rejected, rejected);
                    fails++;
                end
                if (screen_x !== want.screen_x)
                begin
                    $display("%0t: screen_x exp %0h got %0h", $time, want.screen_x, screen_x);
                    fails++;
                end
                if (screen_y !== want.screen_y)
                begin
                    $display("%0t: screen_y exp %0h got %0h", $time, want.screen_y, screen_y);
                    fails++;
                end
                if (depth !== want.depth)
                begin
                    $display("%0t: depth exp %0h got %0h", $time, want.depth, depth);
                    fails++;
                end
                if (depth_reciprocal !== want.depth_reciprocal)
                begin
                    $display("%0t: depth_reciprocal exp %0h got %0h", $time,
                             want.depth_reciprocal, depth_reciprocal);
                    fails++;
                end
            end
        end
    end

    task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic burst);
        stim_t it;
        it = '{op: OP_VERTEX, x: x, y: y, z: z, idx: '0, data: '0, burst: burst};
        pending.push_back(it);
    endtask

    task automatic add_write(logic [3:0] idx, logic [63:0] data);
        stim_t it;
        it = '{op: OP_CFG, x: '0, y: '0, z: '0, idx: idx, data: data, burst: 1'b0};
        pending.push_back(it);
    endtask

    task automatic add_drain();
        stim_t it;
        it = '{op: OP_DRAIN, x: '0, y: '0, z: '0, idx: '0, data: '0, burst: 1'b0};
        pending.push_back(it);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        logic [31:0] v;
        v = $urandom;
        if (mode == 0)
            v = {{12{v[31]}}, v[19:0]};
        return v;
    endfunction

    function automatic logic [63:0] pack_row(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    initial
    begin
        int mode;
        logic burst;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // identity matrix: origin rejected, extremes of each coordinate
        add_vertex(32'd0, 32'd0, 32'd0, 1'b1);
        add_vertex(fpvp_pkg::ONE, fpvp_pkg::ONE, fpvp_pkg::ONE, 1'b1);
        add_vertex(32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1);
        add_vertex(32'h80000000, 32'h7fffffff, 32'h00000001, 1'b0);
        add_vertex(32'hffff0000, 32'h00010000, 32'h80000000, 1'b0);
        add_vertex(32'h0000ffff, 32'hffffffff, 32'h7fffffff, 1'b0);
        // w of -2^31 and w of zero
        add_write(4'(fpvp_pkg::REG_ROW3_COLS23), pack_row(32'd0, 32'h80000000));
        add_vertex(fpvp_pkg::ONE, fpvp_pkg::ONE, fpvp_pkg::ONE, 1'b0);
        add_vertex(32'h00280000, 32'hffd80000, 32'h80000000, 1'b0);
        add_write(4'(fpvp_pkg::REG_ROW3_COLS23), 64'd0);
        add_vertex(fpvp_pkg::ONE, fpvp_pkg::ONE, fpvp_pkg::ONE, 1'b0);
        // writes to indexes above seven leave the matrix untouched
        add_write(REG_UNUSED_LO, 64'hffffffffffffffff);
        add_write(4'd15, 64'h5a5a5a5aa5a5a5a5);
        add_vertex(fpvp_pkg::ONE, fpvp_pkg::ONE, fpvp_pkg::ONE, 1'b0);
        // every register at its extremes, accumulator wraps
        for (int i = 0; i < fpvp_pkg::NUM_REGS; i++)
            add_write(i[3:0], 64'h8000000080000000);
        add_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        add_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        for (int i = 0; i < fpvp_pkg::NUM_REGS; i++)
            add_write(i[3:0], 64'hffffffffffffffff);
        add_vertex(32'h7fffffff, 32'h80000000, 32'h12345678, 1'b0);
        add_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            mode = p % 3;
            burst = (p % 4 == 1);
            for (int i = 0; i < fpvp_pkg::NUM_REGS; i++)
            begin
                if (mode == 1)
                    add_write(i[3:0], {$urandom, $urandom});
                else
                    add_write(i[3:0], pack_row($urandom_range(0, 1) ? $urandom_range(0, 131072)
                                               : -$urandom_range(0, 131072),
                                               $urandom_range(0, 1) ? $urandom_range(0, 131072)
                                               : -$urandom_range(0, 131072)));
            end
            if (mode == 2)
                add_write(4'(fpvp_pkg::REG_ROW3_COLS01), pack_row($urandom_range(0, 3), 32'd0));
            if (p % 3 == 0)
                add_write(4'($urandom_range(8, 15)), {$urandom, $urandom});
            for (int k = 0; k < 100; k++)
            begin
                if (k == 50)
                    add_drain();
                if (mode == 2 && k % 4 == 0)
                    add_vertex($urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 3), burst);
                else
                    add_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), burst);
            end
        end

        while (pending.size() > 0 || start || cfg_valid)
            @(posedge clk);
        while (expected_pixels.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
